>>> src/assert_macros.svh
// Assertion macros shared by the serial mux RTL.
// Active in simulation; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> src/qsm_pkg.sv
// Types and constants of the quad serial mux.
// Used by the port slice, the interrupt unit and the top level.
package qsm_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_RX    = 2'd3;

  localparam logic [3:0] REG_LEVEL   = 4'hA;
  localparam logic [3:0] REG_TXDONE  = 4'hC;
  localparam logic [3:0] REG_IRQ_OFF = 4'hD;
  localparam logic [3:0] REG_IRQ_ON  = 4'hE;
  localparam logic [3:0] REG_RESET   = 4'hF;

  localparam logic [7:0] CAUSE_ADDR = 8'h0F;
  localparam logic [7:0] NO_CAUSE   = 8'hFF;
  localparam logic [7:0] STAT_CTS   = 8'h20;
  localparam logic [7:0] CHAR_DEL   = 8'h7F;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] LAST_RESET = 8'hFF;
  localparam logic [7:0] ASCII_MASK = 8'h7F;

  localparam logic       CFG_CHAR_TICKS = 1'b0;
  localparam logic       CFG_CONSOLE    = 1'b1;
  localparam logic [15:0] CHAR_TICKS_RESET = 16'd1042;

  typedef struct packed {
    logic        tick;
    logic        rd_data;
    logic        wr_data;
    logic        rx_load;
    logic        done_set;
    logic        done_clr;
    logic        card_reset;
    logic        irq_en;
    logic        raw;
    logic [15:0] char_time;
    logic [7:0]  rx_byte;
  } port_ctrl_t;

  typedef struct packed {
    logic       rx_full;
    logic       tx_free;
    logic       rx_idle;
    logic       rx_full_nx;
    logic       tx_done_nx;
    logic [7:0] rd_char;
  } port_stat_t;

  typedef struct packed {
    logic       tick;
    logic       set_level;
    logic [7:0] level;
    logic       enable_on;
    logic       enable_off;
    logic       card_reset;
  } irq_ctrl_t;

endpackage

>>> src/qsm_ifs.sv
// Request and result channels of the quad serial mux.
// Valid/ready handshake; no package dependency.
interface qsm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] address;
  logic [7:0] write_data;
  logic [1:0] rx_port;
  logic [7:0] rx_byte;

  modport source (output valid, command, address, write_data, rx_port, rx_byte,
                  input ready);
  modport sink (input valid, command, address, write_data, rx_port, rx_byte,
                output ready);
endinterface

interface qsm_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       tx_valid;
  logic [1:0] tx_port;
  logic [7:0] tx_byte;
  logic       busy_write;
  logic       rx_dropped;
  logic       irq_request;
  logic [7:0] irq_line_level;

  modport source (output valid, read_data, tx_valid, tx_port, tx_byte, busy_write,
                  rx_dropped, irq_request, irq_line_level, input ready);
  modport sink (input valid, read_data, tx_valid, tx_port, tx_byte, busy_write,
                rx_dropped, irq_request, irq_line_level, output ready);
endinterface

>>> src/quad_serial_mux_with_irq.sv
// Quad serial mux with interrupt: takes one item (tick, bus read, bus write or
// received byte) per clock while the result channel is not stalled and returns one
// result per item. An accepted item is held in the input register, is decoded and
// applied to the port and interrupt state in a single read-modify-write pass, and its
// result is registered in the output register; the input register takes a new item as
// the current one moves out. There is no clearing pass after reset. The user must write
// char_ticks and console_ports through the cfg port only while no item is in flight;
// the block itself does not enforce it.
`include "assert_macros.svh"

module quad_serial_mux_with_irq
  import qsm_pkg::*;
#(
  parameter int PORTS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wr_data,
  qsm_req_if.sink     req,
  qsm_rsp_if.source   rsp
);

  localparam int PW = (PORTS > 1) ? $clog2(PORTS) : 1;

  logic [15:0] char_ticks;
  logic [3:0]  console_ports;

  logic       s_valid;
  logic [1:0] s_cmd;
  logic [7:0] s_addr;
  logic [7:0] s_wd;
  logic [1:0] s_rport;
  logic [7:0] s_rbyte;
  logic       advance;

  logic [3:0]    card, rg;
  logic [5:0]    unit;
  logic          unit_ok;
  logic [PW-1:0] port_sel;
  logic          is_read, is_write, is_rx, is_tick;
  logic          cause_rd, rd_hit, wr_data_hit, wr_ctrl;
  logic [15:0]   char_time;

  port_ctrl_t       pc   [PORTS];
  port_stat_t       stat [PORTS];
  logic [PORTS-1:0] raw_vec, rx_take, rx_full_nx, tx_done_nx;
  logic             rx_ok;

  irq_ctrl_t  ic;
  logic       irq_en;
  logic [7:0] cause, cause_next, level_next;
  logic [7:0] rd_val, tx_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_ticks    <= CHAR_TICKS_RESET;
      console_ports <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_CHAR_TICKS: char_ticks    <= cfg_wr_data;
        CFG_CONSOLE:    console_ports <= cfg_wr_data[3:0];
        default:        ;
      endcase
    end
  end

  assign advance   = s_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s_cmd   <= req.command;
      s_addr  <= req.address;
      s_wd    <= req.write_data;
      s_rport <= req.rx_port;
      s_rbyte <= req.rx_byte;
    end
  end

  always_comb begin
    card        = s_addr[7:4];
    rg          = s_addr[3:0];
    unit        = rg[3] ? {card, 2'b00} : {card, rg[2:1]};
    unit_ok     = unit < 6'(PORTS);
    port_sel    = unit[PW-1:0];
    is_tick     = s_cmd == CMD_TICK;
    is_read     = s_cmd == CMD_READ;
    is_write    = s_cmd == CMD_WRITE;
    is_rx       = s_cmd == CMD_RX;
    cause_rd    = is_read && s_addr == CAUSE_ADDR;
    rd_hit      = is_read && unit_ok && !rg[3];
    wr_data_hit = is_write && unit_ok && !rg[3] && rg[0];
    wr_ctrl     = is_write && unit_ok && rg[3];
    char_time   = (char_ticks == '0) ? 16'd1 : char_ticks;
  end

  for (genvar i = 0; i < PORTS; i++) begin : g_port
    if (i < 4) begin : g_low
      assign raw_vec[i] = console_ports[i];
      assign rx_take[i] = is_rx && s_rport == 2'(i) && stat[i].rx_idle;
    end else begin : g_high
      assign raw_vec[i] = 1'b0;
      assign rx_take[i] = 1'b0;
    end

    always_comb begin
      pc[i].tick       = advance && is_tick;
      pc[i].rd_data    = advance && rd_hit && rg[0] && port_sel == PW'(i);
      pc[i].wr_data    = advance && wr_data_hit && port_sel == PW'(i);
      pc[i].rx_load    = advance && rx_take[i];
      pc[i].done_set   = advance && wr_ctrl && rg == REG_TXDONE && s_wd == 8'(i + 1);
      pc[i].done_clr   = advance && cause_rd && cause != NO_CAUSE && cause[0]
                         && cause[7:1] == 7'(i);
      pc[i].card_reset = advance && wr_ctrl && rg == REG_RESET;
      pc[i].irq_en     = irq_en;
      pc[i].raw        = raw_vec[i];
      pc[i].char_time  = char_time;
      pc[i].rx_byte    = s_rbyte;
    end

    qsm_port u_port (
      .clk  (clk),
      .rst  (rst),
      .ctrl (pc[i]),
      .stat (stat[i])
    );

    assign rx_full_nx[i] = stat[i].rx_full_nx;
    assign tx_done_nx[i] = stat[i].tx_done_nx;
  end

  assign rx_ok = |rx_take;

  always_comb begin
    ic.tick       = advance && is_tick;
    ic.set_level  = advance && wr_ctrl && rg == REG_LEVEL;
    ic.level      = s_wd;
    ic.enable_on  = advance && wr_ctrl && rg == REG_IRQ_ON;
    ic.enable_off = advance && wr_ctrl && rg == REG_IRQ_OFF;
    ic.card_reset = advance && wr_ctrl && rg == REG_RESET;
  end

  qsm_irq #(.PORTS(PORTS)) u_irq (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ic),
    .rx_full_nx  (rx_full_nx),
    .tx_done_nx  (tx_done_nx),
    .enable      (irq_en),
    .cause       (cause),
    .cause_next  (cause_next),
    .level_next  (level_next)
  );

  always_comb begin
    rd_val = '0;
    if (cause_rd) begin
      rd_val = cause;
    end else if (rd_hit) begin
      rd_val = rg[0] ? stat[port_sel].rd_char
                     : (STAT_CTS | {6'd0, stat[port_sel].tx_free, stat[port_sel].rx_full});
    end
    tx_val = raw_vec[port_sel] ? s_wd : (s_wd & ASCII_MASK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.read_data      <= rd_val;
      rsp.tx_valid       <= wr_data_hit;
      rsp.tx_port        <= wr_data_hit ? unit[1:0] : 2'd0;
      rsp.tx_byte        <= wr_data_hit ? tx_val : 8'd0;
      rsp.busy_write     <= wr_data_hit && !stat[port_sel].tx_free;
      rsp.rx_dropped     <= is_rx && !rx_ok;
      rsp.irq_request    <= cause_next != NO_CAUSE;
      rsp.irq_line_level <= level_next;
    end
  end

  `ASSERT_IMPLIES(a_irq_matches_cause, clk, rst, rsp.valid, rsp.irq_request == (cause != NO_CAUSE))
  `ASSERT_IMPLIES(a_idle_tx_clear, clk, rst, rsp.valid && !rsp.tx_valid, rsp.tx_port == 2'd0 && rsp.tx_byte == 8'd0)
  `ASSERT_IMPLIES(a_cause_in_range, clk, rst, cause != NO_CAUSE, cause[7:1] < 7'(PORTS))
  `ASSERT_NEXT(a_advance_shows_result, clk, rst, advance, rsp.valid)
  `ASSERT_NEXT(a_masked_tick_no_cause, clk, rst, advance && is_tick && !irq_en, cause == NO_CAUSE)

endmodule

>>> src/qsm_port.sv
// One serial port slice: ready flags, last and held bytes, character countdowns.
// Depends on qsm_pkg for the control and status structs.
module qsm_port
  import qsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  port_ctrl_t ctrl,
  output port_stat_t stat
);

  logic        rx_full, rx_full_next;
  logic        tx_free, tx_free_next;
  logic        tx_done, tx_done_next;
  logic [7:0]  last_char, last_char_next;
  logic [7:0]  held_byte;
  logic [15:0] rx_cnt, rx_cnt_next;
  logic [15:0] tx_cnt, tx_cnt_next;
  logic [7:0]  conv_char;

  always_comb begin
    conv_char = (!ctrl.raw && held_byte == CHAR_DEL) ? CHAR_BS : held_byte;
    stat.rd_char = rx_full ? conv_char : last_char;
  end

  always_comb begin
    rx_full_next   = rx_full;
    tx_free_next   = tx_free;
    tx_done_next   = tx_done;
    last_char_next = last_char;
    rx_cnt_next    = rx_cnt;
    tx_cnt_next    = tx_cnt;
    if (ctrl.card_reset) begin
      rx_full_next   = 1'b0;
      tx_free_next   = 1'b1;
      tx_done_next   = 1'b0;
      last_char_next = LAST_RESET;
      rx_cnt_next    = '0;
      tx_cnt_next    = '0;
    end else begin
      if (ctrl.tick) begin
        if (rx_cnt != '0) begin
          rx_cnt_next = rx_cnt - 16'd1;
          if (rx_cnt == 16'd1) rx_full_next = 1'b1;
        end
        if (tx_cnt != '0) begin
          tx_cnt_next = tx_cnt - 16'd1;
          if (tx_cnt == 16'd1) begin
            tx_free_next = 1'b1;
            if (ctrl.irq_en) tx_done_next = 1'b1;
          end
        end
      end
      if (ctrl.rd_data) begin
        if (rx_full) last_char_next = conv_char;
        rx_full_next = 1'b0;
      end
      if (ctrl.wr_data) begin
        tx_free_next = 1'b0;
        tx_cnt_next  = ctrl.char_time;
      end
      if (ctrl.rx_load) rx_cnt_next = ctrl.char_time;
      if (ctrl.done_set) tx_done_next = 1'b1;
      if (ctrl.done_clr) tx_done_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_full   <= 1'b0;
      tx_free   <= 1'b1;
      tx_done   <= 1'b0;
      last_char <= LAST_RESET;
      rx_cnt    <= '0;
      tx_cnt    <= '0;
    end else begin
      rx_full   <= rx_full_next;
      tx_free   <= tx_free_next;
      tx_done   <= tx_done_next;
      last_char <= last_char_next;
      rx_cnt    <= rx_cnt_next;
      tx_cnt    <= tx_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rx_load) held_byte <= ctrl.rx_byte;
  end

  assign stat.rx_full    = rx_full;
  assign stat.tx_free    = tx_free;
  assign stat.rx_idle    = !rx_full && rx_cnt == '0;
  assign stat.rx_full_nx = rx_full_next;
  assign stat.tx_done_nx = tx_done_next;

endmodule

>>> src/qsm_irq.sv
// Interrupt level, enable and cause registers with the fixed-priority cause encoder.
// Depends on qsm_pkg for irq_ctrl_t and the cause constants.
module qsm_irq
  import qsm_pkg::*;
#(
  parameter int PORTS = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  irq_ctrl_t        ctrl,
  input  logic [PORTS-1:0] rx_full_nx,
  input  logic [PORTS-1:0] tx_done_nx,
  output logic             enable,
  output logic [7:0]       cause,
  output logic [7:0]       cause_next,
  output logic [7:0]       level_next
);

  logic [7:0] level;
  logic       enable_next;
  logic [7:0] enc;

  always_comb begin
    enc = NO_CAUSE;
    for (int i = PORTS - 1; i >= 0; i--) begin
      if (rx_full_nx[i]) enc = {7'(i), 1'b0};
      else if (tx_done_nx[i]) enc = {7'(i), 1'b1};
    end
  end

  always_comb begin
    cause_next  = cause;
    level_next  = level;
    enable_next = enable;
    if (ctrl.card_reset) begin
      cause_next  = NO_CAUSE;
      level_next  = '0;
      enable_next = 1'b0;
    end else begin
      if (ctrl.tick) cause_next = enable ? enc : NO_CAUSE;
      if (ctrl.set_level) level_next = ctrl.level;
      if (ctrl.enable_on) enable_next = 1'b1;
      if (ctrl.enable_off) enable_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cause  <= NO_CAUSE;
      level  <= '0;
      enable <= 1'b0;
    end else begin
      cause  <= cause_next;
      level  <= level_next;
      enable <= enable_next;
    end
  end

endmodule
